// ----- rtl/hbt_pkg.sv -----
// shared types and constants of the held button timeout table
package hbt_pkg;

	// function codes of an input beat
	localparam logic [1:0] FUNC_PRESS   = 2'd0;
	localparam logic [1:0] FUNC_SCAN    = 2'd1;
	localparam logic [1:0] FUNC_REFRESH = 2'd2;

	// event kinds of a result beat
	localparam logic EVT_PRESS   = 1'b0;
	localparam logic EVT_RELEASE = 1'b1;

	// reset value of the timeout register
	localparam logic [7:0] TIMEOUT_RESET = 8'd100;

	// width of the slot index field
	localparam int SLOT_W = 3;

	// broadcast from the top level to every cell at the accept edge
	typedef struct packed {
		logic       press;
		logic       scan;
		logic       refresh;
		logic [7:0] now;
		logic [7:0] addr;
		logic [7:0] button;
		logic [7:0] timeout;
	} cmd_t;

	// token handed from cell to cell, one hop per cycle while the chain is not stalled
	typedef struct packed {
		logic       valid;
		logic       scan;
		logic       done;
		logic [7:0] now;
		logic [7:0] addr;
		logic [7:0] button;
	} token_t;

	// release event offered by a cell
	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] addr;
		logic [7:0] button;
	} emit_t;

endpackage

// ----- rtl/hbt_cell.sv -----
// one table slot with its share of the token chain
module hbt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  hbt_pkg::cmd_t   cmd,
	input  hbt_pkg::token_t tok_in,
	input  logic           stall,
	input  logic           more_in,
	output hbt_pkg::token_t tok_q,
	output logic           more_out,
	output logic           match,
	output logic           want_emit,
	output hbt_pkg::emit_t  emit
);
	import hbt_pkg::*;

	logic [7:0] addr_q;
	logic [7:0] button_q;
	logic [7:0] stamp_q;
	logic       exp_q;
	logic       occupied;
	logic [7:0] age;
	logic       take;
	logic       fill;
	token_t     tok_next;

	// slot state seen by the broadcast
	assign occupied = (addr_q != 8'd0);
	assign match    = occupied && (addr_q == cmd.addr) && (button_q == cmd.button);
	assign age      = cmd.now - stamp_q;

	// token arrives here and the chain moves this cycle
	assign take      = tok_in.valid && !stall;
	assign fill      = take && !tok_in.scan && !tok_in.done && !occupied;
	assign want_emit = tok_in.valid && tok_in.scan && exp_q;

	// release beat for this slot, last when no higher slot still expires
	assign emit.valid  = want_emit && !stall;
	assign emit.last   = !more_in;
	assign emit.addr   = addr_q;
	assign emit.button = button_q;

	assign more_out = exp_q || more_in;

	// token passed on, marked done once the press is stored
	always_comb begin
		tok_next = tok_in;
		if (fill) begin
			tok_next.done = 1'b1;
		end
	end

	// control state: occupancy and expiry flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 8'd0;
			exp_q  <= 1'b0;
			tok_q  <= '0;
		end else begin
			if (!stall) begin
				tok_q <= tok_next;
			end
			if (cmd.scan) begin
				exp_q <= occupied && (age > cmd.timeout);
			end else if (emit.valid) begin
				exp_q <= 1'b0;
			end
			if (fill) begin
				addr_q <= tok_in.addr;
			end else if (emit.valid) begin
				addr_q <= 8'd0;
			end
		end
	end

	// payload: button and stamp
	always_ff @(posedge clk) begin
		if (fill) begin
			button_q <= tok_in.button;
			stamp_q  <= tok_in.now;
		end else if ((cmd.press && match) || (cmd.refresh && occupied)) begin
			stamp_q <= cmd.now;
		end
	end

endmodule

// ----- rtl/held_button_timeout_table.sv -----
// top level of the held button timeout table: cell chain and result register
//
// Input channel (in_valid/in_ready) takes one beat of func, now_ms,
// bus_address and button_number. Result channel (out_valid/out_ready)
// gives event_kind, is_new, slot_index, event_address, event_button, last.
// The cfg channel writes timeout_ms; cfg_ready is always high.
// A press is looked up in all slots at the accept edge and its answer is
// in the result register in the cycle after. A press of an unknown pair then
// sends a token down the chain of TABLE_DEPTH cells to fill the lowest
// empty slot; a scan sends a token that releases expired slots one per
// cycle as it passes while the chain is not held, lowest slot first. The
// next beat is taken once the token has left the chain; a known press,
// a refresh or func 3 sends no token.
// A release beat waiting on out_ready holds the whole chain in place.
// A new beat is only taken when the result register is empty or drains.
// Reset empties every slot, clears the chain and the result register
// and sets the timeout to 100 ms; no clearing pass is needed.
module held_button_timeout_table #(
	parameter int TABLE_DEPTH = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] now_ms,
	input  logic [7:0] bus_address,
	input  logic [7:0] button_number,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       event_kind,
	output logic       is_new,
	output logic [hbt_pkg::SLOT_W-1:0] slot_index,
	output logic [7:0] event_address,
	output logic [7:0] event_button,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import hbt_pkg::*;

	logic [7:0]              timeout_q;
	cmd_t                    cmd;
	token_t                  launch_q;
	token_t                  tok [TABLE_DEPTH+1];
	logic [TABLE_DEPTH:0]    more;
	logic [TABLE_DEPTH-1:0]  match;
	logic [TABLE_DEPTH-1:0]  want_emit;
	logic [TABLE_DEPTH-1:0]  tok_busy;
	emit_t                   emit [TABLE_DEPTH];
	logic                    in_accept;
	logic                    found;
	logic                    busy;
	logic                    stall;
	logic                    rel_valid;
	logic                    rel_last;
	logic [7:0]              rel_addr;
	logic [7:0]              rel_button;
	logic [SLOT_W-1:0]       rel_slot;
	logic                    out_valid_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// input handshake and broadcast to the cells
	assign busy      = launch_q.valid || (|tok_busy);
	assign in_ready  = !busy && (!out_valid_q || out_ready);
	assign in_accept = in_valid && in_ready;
	assign found     = |match;

	assign cmd.press   = in_accept && (func == FUNC_PRESS);
	assign cmd.scan    = in_accept && (func == FUNC_SCAN);
	assign cmd.refresh = in_accept && (func == FUNC_REFRESH);
	assign cmd.now     = now_ms;
	assign cmd.addr    = bus_address;
	assign cmd.button  = button_number;
	assign cmd.timeout = timeout_q;

	// a release waiting on a full result register holds the chain
	assign stall = (|want_emit) && out_valid_q && !out_ready;

	// token launch: scan, or press of an unknown pair from a real sender
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else if (in_accept) begin
			launch_q.valid  <= cmd.scan ||
			                   (cmd.press && !found && (bus_address != 8'd0));
			launch_q.scan   <= cmd.scan;
			launch_q.done   <= 1'b0;
			launch_q.now    <= now_ms;
			launch_q.addr   <= bus_address;
			launch_q.button <= button_number;
		end else if (!stall) begin
			launch_q.valid <= 1'b0;
		end
	end

	// chain of slot cells
	assign tok[0]            = launch_q;
	assign more[TABLE_DEPTH] = 1'b0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		hbt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.tok_in    (tok[i]),
			.stall     (stall),
			.more_in   (more[i+1]),
			.tok_q     (tok[i+1]),
			.more_out  (more[i]),
			.match     (match[i]),
			.want_emit (want_emit[i]),
			.emit      (emit[i])
		);
		assign tok_busy[i] = tok[i+1].valid;
	end

	// pick the one release beat offered this cycle
	always_comb begin
		rel_valid  = 1'b0;
		rel_last   = 1'b0;
		rel_addr   = 8'd0;
		rel_button = 8'd0;
		rel_slot   = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (emit[i].valid) begin
				rel_valid  = 1'b1;
				rel_last   = emit[i].last;
				rel_addr   = emit[i].addr;
				rel_button = emit[i].button;
				rel_slot   = SLOT_W'(i);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.press || rel_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.press) begin
			event_kind    <= EVT_PRESS;
			is_new        <= !found;
			slot_index    <= '0;
			event_address <= bus_address;
			event_button  <= button_number;
			last          <= 1'b1;
		end else if (rel_valid) begin
			event_kind    <= EVT_RELEASE;
			is_new        <= 1'b0;
			slot_index    <= rel_slot;
			event_address <= rel_addr;
			event_button  <= rel_button;
			last          <= rel_last;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_one_release: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(want_emit))
		else $error("more than one cell offers a release");

	a_press_answer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.press |=> out_valid && (event_kind == EVT_PRESS) && last)
		else $error("press answer missing");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("input taken while token in chain");

	a_release_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind == EVT_RELEASE)) |-> !is_new &&
		(event_address != 8'd0))
		else $error("release beat of an empty slot");

endmodule

// ----- dv/tb.sv -----
// testbench of the held button timeout table: directed and random beats against a table predictor
`timescale 1ns / 100ps

module tb;
	import hbt_pkg::*;

	localparam int TABLE_DEPTH = 5;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 6;
	localparam int HOLD_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 1500;
	localparam int REPORT_LIMIT = 10;

	// one result beat as the table reports it
	typedef struct packed {
		logic              kind;
		logic              is_new;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        addr;
		logic [7:0]        button;
		logic              last;
	} table_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        func = FUNC_PRESS;
	logic [7:0]        now_ms = 8'd0;
	logic [7:0]        bus_address = 8'd0;
	logic [7:0]        button_number = 8'd0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              event_kind;
	logic              is_new;
	logic [SLOT_W-1:0] slot_index;
	logic [7:0]        event_address;
	logic [7:0]        event_button;
	logic              last;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [7:0]        cfg_data = 8'd0;

	// predicted table contents and timeout
	logic [7:0] held_addr [TABLE_DEPTH];
	logic [7:0] held_button [TABLE_DEPTH];
	logic [7:0] held_stamp [TABLE_DEPTH];
	logic [7:0] timeout_now = TIMEOUT_RESET;

	table_event_t pending_events [$];
	int           mismatches = 0;
	bit           calm = 1'b0;
	int           holds_asked = 0;
	int           holds_granted = 0;
	int           hold_left = 0;
	int           idle_cycles = 0;
	logic [7:0]   ms_clock = 8'd0;

	held_button_timeout_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.now_ms       (now_ms),
		.bus_address  (bus_address),
		.button_number(button_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.is_new       (is_new),
		.slot_index   (slot_index),
		.event_address(event_address),
		.event_button (event_button),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// table predictor: updates the held slots and queues the expected beats
	task automatic predict_table_beat(input logic [1:0] f, input logic [7:0] now,
			input logic [7:0] addr, input logic [7:0] button);
		int           free_slot;
		bit           hit;
		int           expiring;
		int           emitted;
		logic [7:0]   age;
		table_event_t ev;
		free_slot = -1;
		hit = 1'b0;
		expiring = 0;
		emitted = 0;
		case (f)
			FUNC_PRESS: begin
				if (addr != 8'd0) begin
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (held_addr[i] == 8'd0) begin
							if (free_slot < 0)
								free_slot = i;
						end else if (held_addr[i] == addr && held_button[i] == button) begin
							held_stamp[i] = now;
							hit = 1'b1;
							break;
						end
					end
					// full table: answered as new but not stored
					if (!hit && free_slot >= 0) begin
						held_addr[free_slot] = addr;
						held_button[free_slot] = button;
						held_stamp[free_slot] = now;
					end
				end
				ev = '{EVT_PRESS, !hit, '0, addr, button, 1'b1};
				pending_events.push_back(ev);
			end
			FUNC_SCAN: begin
				// count first so the final release carries last
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					age = now - held_stamp[i];
					if (held_addr[i] != 8'd0 && age > timeout_now)
						expiring++;
				end
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					age = now - held_stamp[i];
					if (held_addr[i] != 8'd0 && age > timeout_now) begin
						emitted++;
						ev = '{EVT_RELEASE, 1'b0, SLOT_W'(i), held_addr[i], held_button[i],
							emitted == expiring};
						pending_events.push_back(ev);
						held_addr[i] = 8'd0;
					end
				end
			end
			FUNC_REFRESH: begin
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (held_addr[i] != 8'd0)
						held_stamp[i] = now;
			end
			default: begin
			end
		endcase
	endtask

	// offer one input beat, with an optional gap, and predict it once accepted
	task automatic send_beat(input logic [1:0] f, input logic [7:0] now,
			input logic [7:0] addr, input logic [7:0] button);
		int gap;
		gap = (!calm && $urandom_range(99) < 31) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		now_ms <= now;
		bus_address <= addr;
		button_number <= button;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_table_beat(f, now, addr, button);
	endtask

	// stop offering, let all results drain and the chain settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [7:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		timeout_now = value;
	endtask

	// mostly a small address pool on a slowly advancing clock, some noise
	task automatic send_random_beat();
		int         pick;
		logic [1:0] f;
		logic [7:0] addr;
		logic [7:0] button;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 4)
			ms_clock = 8'($urandom);
		else
			ms_clock = ms_clock + 8'($urandom_range(0, 12));
		addr = 8'($urandom_range(1, 6));
		button = 8'($urandom_range(0, 2));
		if (pick < 55) begin
			f = FUNC_PRESS;
		end else if (pick < 78) begin
			f = FUNC_SCAN;
		end else if (pick < 86) begin
			f = FUNC_REFRESH;
		end else if (pick < 90) begin
			f = FUNC_UNUSED;
			addr = 8'($urandom);
			button = 8'($urandom);
		end else begin
			f = FUNC_PRESS;
			addr = 8'($urandom);
			button = 8'($urandom);
		end
		send_beat(f, ms_clock, addr, button);
	endtask

	// lookup, refresh of a known pair, address zero, filling and overflow
	task automatic test_press_paths();
		send_beat(FUNC_PRESS, 8'd10, 8'h01, 8'h00);
		send_beat(FUNC_PRESS, 8'd12, 8'h01, 8'h00);
		send_beat(FUNC_PRESS, 8'd14, 8'h00, 8'h05);
		send_beat(FUNC_PRESS, 8'd16, 8'hff, 8'hff);
		send_beat(FUNC_PRESS, 8'd18, 8'h01, 8'hff);
		send_beat(FUNC_PRESS, 8'd20, 8'h80, 8'h01);
		send_beat(FUNC_PRESS, 8'd22, 8'h02, 8'h80);
		send_beat(FUNC_PRESS, 8'd24, 8'h03, 8'h03);
		send_beat(FUNC_PRESS, 8'd26, 8'hff, 8'hff);
	endtask

	// nothing expired, age equal to timeout, several releases, wrapped age
	task automatic test_scan_release();
		send_beat(FUNC_SCAN, 8'd100, 8'h00, 8'h00);
		send_beat(FUNC_SCAN, 8'd118, 8'h00, 8'h00);
		send_beat(FUNC_PRESS, 8'd119, 8'h01, 8'h00);
		send_beat(FUNC_SCAN, 8'd130, 8'h00, 8'h00);
		send_beat(FUNC_PRESS, 8'd250, 8'h10, 8'h20);
		send_beat(FUNC_SCAN, 8'd4, 8'h00, 8'h00);
	endtask

	// refresh keeps a slot alive, func 3 is ignored
	task automatic test_refresh_and_unused();
		send_beat(FUNC_REFRESH, 8'd200, 8'h00, 8'h00);
		send_beat(FUNC_UNUSED, 8'd255, 8'haa, 8'h55);
		send_beat(FUNC_SCAN, 8'd250, 8'h00, 8'h00);
		send_beat(FUNC_SCAN, 8'h47, 8'h00, 8'h00);
	endtask

	// zero timeout releases after one tick, full timeout never releases
	task automatic test_timeout_extremes();
		set_timeout(8'd0);
		send_beat(FUNC_PRESS, 8'd5, 8'h21, 8'h01);
		send_beat(FUNC_PRESS, 8'd5, 8'h22, 8'h02);
		send_beat(FUNC_SCAN, 8'd5, 8'h00, 8'h00);
		send_beat(FUNC_SCAN, 8'd6, 8'h00, 8'h00);
		set_timeout(8'd255);
		send_beat(FUNC_PRESS, 8'd0, 8'h40, 8'h7f);
		send_beat(FUNC_SCAN, 8'd255, 8'h00, 8'h00);
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_backpressure();
		set_timeout(8'd20);
		holds_asked++;
		repeat (20) send_random_beat();
	endtask

	task automatic test_random_traffic();
		logic [7:0] settings [4];
		settings = '{8'($urandom_range(30, 90)), 8'd8, 8'($urandom), 8'd200};
		foreach (settings[p]) begin
			set_timeout(settings[p]);
			calm = (p == 2);
			repeat (60) send_random_beat();
		end
		calm = 1'b0;
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			if (mismatches < REPORT_LIMIT)
				$display("mismatch in %s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// compare every accepted result beat with the oldest expectation
	always @(posedge clk) begin
		table_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("result beat with nothing pending: kind %0d addr %0h button %0h",
						event_kind, event_address, event_button);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", want.kind, event_kind);
				check_field("is_new", want.is_new, is_new);
				check_field("slot_index", want.slot, slot_index);
				check_field("event_address", want.addr, event_address);
				check_field("event_button", want.button, event_button);
				check_field("last", want.last, last);
			end
		end
	end

	// receiver: random stalls, calm stretches and a requested long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (holds_granted != holds_asked) begin
			out_ready <= 1'b0;
			hold_left = HOLD_CYCLES;
			holds_granted = holds_granted + 1;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 31);
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			held_addr[i] = 8'd0;
			held_button[i] = 8'd0;
			held_stamp[i] = 8'd0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_press_paths();
		test_scan_release();
		test_refresh_and_unused();
		test_timeout_extremes();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
